FILE: sv/dcd_pkg.sv
package dcd_pkg;

	localparam int DELTA_W = 16;
	localparam int SCALE_W = 18;
	localparam int CFG_W   = 18;
	localparam int IDX_W   = 2;
	localparam int EV_W    = 3;
	localparam int DIGIT_W = 16;
	localparam int THR_W   = 48;
	localparam int DIGITS  = 3;

	localparam logic [IDX_W-1:0] REG_DELTA_UP   = 2'd0;
	localparam logic [IDX_W-1:0] REG_DELTA_DOWN = 2'd1;
	localparam logic [IDX_W-1:0] REG_SCALE      = 2'd2;

	localparam logic [DELTA_W-1:0] DELTA_UP_RST   = 16'd655;
	localparam logic [DELTA_W-1:0] DELTA_DOWN_RST = 16'd655;
	localparam logic [SCALE_W-1:0] SCALE_RST      = 18'd165526;

	typedef enum logic [EV_W-1:0] {
		EV_NONE     = 3'd0,
		EV_UP_OS    = 3'd1,
		EV_CHG_DOWN = 3'd2,
		EV_DOWN_OS  = 3'd3,
		EV_CHG_UP   = 3'd4
	} event_t;

endpackage

FILE: sv/dcd_price_if.sv
interface dcd_price_if #(
	parameter int PRICE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic [PRICE_WIDTH-1:0] price;

	modport source (output valid, output price, input ready);
	modport sink   (input valid, input price, output ready);
endinterface

FILE: sv/dcd_event_if.sv
interface dcd_event_if;
	logic                       valid;
	logic                       ready;
	logic [dcd_pkg::EV_W-1:0]   event_code;
	logic [dcd_pkg::EV_W-1:0]   scaled_event_code;

	modport source (output valid, output event_code, output scaled_event_code, input ready);
	modport sink   (input valid, input event_code, input scaled_event_code, output ready);
endinterface

FILE: sv/directional_change_detector.sv
// an accepted word runs the plain tracker through SETUP, MUL and CMP, then the scaled
// tracker through SETUP, THR for its threshold product on an overshoot, MUL and CMP;
// OUT then raises the result word once the last is taken; words enter only in IDLE;
// both trackers share one 16-bit-digit multiplier, three digit passes per tracker
// reset: arst_n clears both trackers to unseeded up mode and loads the register defaults
module directional_change_detector #(
	parameter int PRICE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dcd_price_if.sink                     samples,
	dcd_event_if.source                   events,
	input  logic                          write_enable,
	input  logic [dcd_pkg::IDX_W-1:0]     reg_index,
	input  logic [dcd_pkg::CFG_W-1:0]     write_data
);

	localparam int PW = PRICE_WIDTH;
	localparam int MW = (PRICE_WIDTH > dcd_pkg::SCALE_W) ? PRICE_WIDTH : dcd_pkg::SCALE_W;
	localparam int AW = PRICE_WIDTH + dcd_pkg::THR_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_THR,
		ST_MUL,
		ST_CMP,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [dcd_pkg::DELTA_W-1:0] delta_up_q;
	logic [dcd_pkg::DELTA_W-1:0] delta_down_q;
	logic [dcd_pkg::SCALE_W-1:0] scale_q;

	logic [1:0]          started_q;
	logic [1:0]          mode_down_q;
	logic [1:0][PW-1:0]  extreme_q;
	logic [1:0][PW-1:0]  reference_q;

	logic                trk_q;
	logic [1:0]          k_q;
	logic [PW-1:0]       price_q;
	logic [PW-1:0]       ext_eff_q;
	logic [PW-1:0]       ref_eff_q;
	logic                md_eff_q;
	logic                moved_q;
	logic                ok_q;
	logic                shift32_q;
	logic [PW-1:0]       diff_q;
	logic [PW-1:0]       base_q;
	logic [dcd_pkg::DELTA_W-1:0] d_q;
	logic [dcd_pkg::THR_W-1:0]   thr_q;
	logic [AW-1:0]       acc_q;

	logic                        events_valid_q;
	logic [dcd_pkg::EV_W-1:0]    ev_plain_q;
	logic [dcd_pkg::EV_W-1:0]    ev_scaled_q;
	logic [dcd_pkg::EV_W-1:0]    out_plain_q;
	logic [dcd_pkg::EV_W-1:0]    out_scaled_q;

	// tracker view with seeding applied
	logic          st_c;
	logic          md_c;
	logic [PW-1:0] ex_c;
	logic [PW-1:0] rf_c;
	logic          moved_c;
	logic          ok_c;
	logic [PW-1:0] diff_c;
	logic [dcd_pkg::DELTA_W-1:0] d_c;

	logic [MW-1:0]    mul_a;
	logic [dcd_pkg::DIGIT_W-1:0] mul_b;
	logic [MW+15:0]   prod;
	logic [AW-1:0]    lhs;
	logic             pass;
	logic [dcd_pkg::EV_W-1:0] ev_c;

	always_comb begin
		st_c = started_q[trk_q];
		md_c = st_c ? mode_down_q[trk_q] : 1'b0;
		ex_c = st_c ? extreme_q[trk_q] : price_q;
		rf_c = st_c ? reference_q[trk_q] : price_q;
		moved_c = md_c ? (price_q < ex_c) : (price_q > ex_c);
		unique case ({moved_c, md_c})
			2'b10: begin
				diff_c = price_q - rf_c;
				ok_c   = price_q > rf_c;
			end
			2'b11: begin
				diff_c = rf_c - price_q;
				ok_c   = rf_c > price_q;
			end
			2'b00: begin
				diff_c = ex_c - price_q;
				ok_c   = 1'b1;
			end
			default: begin
				diff_c = price_q - ex_c;
				ok_c   = 1'b1;
			end
		endcase
		d_c = (moved_c ^ md_c) ? delta_up_q : delta_down_q;
	end

	assign mul_a = (state_q == ST_THR) ? MW'(scale_q) : MW'(base_q);
	assign mul_b = (state_q == ST_THR) ? d_q : thr_q[{k_q, 4'b0000} +: dcd_pkg::DIGIT_W];
	assign prod  = mul_a * mul_b;

	assign lhs  = shift32_q ? (AW'(diff_q) << 32) : (AW'(diff_q) << 16);
	assign pass = ok_q && (lhs > acc_q);

	always_comb begin
		if (moved_q) begin
			ev_c = pass ? (md_eff_q ? dcd_pkg::EV_DOWN_OS : dcd_pkg::EV_UP_OS)
			            : dcd_pkg::EV_NONE;
		end else begin
			ev_c = pass ? (md_eff_q ? dcd_pkg::EV_CHG_UP : dcd_pkg::EV_CHG_DOWN)
			            : dcd_pkg::EV_NONE;
		end
	end

	assign samples.ready            = (state_q == ST_IDLE);
	assign events.valid             = events_valid_q;
	assign events.event_code        = out_plain_q;
	assign events.scaled_event_code = out_scaled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_up_q   <= dcd_pkg::DELTA_UP_RST;
			delta_down_q <= dcd_pkg::DELTA_DOWN_RST;
			scale_q      <= dcd_pkg::SCALE_RST;
		end else if (write_enable) begin
			unique case (reg_index)
				dcd_pkg::REG_DELTA_UP:   delta_up_q   <= write_data[dcd_pkg::DELTA_W-1:0];
				dcd_pkg::REG_DELTA_DOWN: delta_down_q <= write_data[dcd_pkg::DELTA_W-1:0];
				dcd_pkg::REG_SCALE:      scale_q      <= write_data[dcd_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			started_q      <= '0;
			mode_down_q    <= '0;
			extreme_q      <= '0;
			reference_q    <= '0;
			trk_q          <= 1'b0;
			k_q            <= '0;
			events_valid_q <= 1'b0;
		end else begin
			if (events_valid_q && events.ready && state_q != ST_OUT) begin
				events_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						price_q <= samples.price[PW-1:0];
						trk_q   <= 1'b0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					ext_eff_q <= ex_c;
					ref_eff_q <= rf_c;
					md_eff_q  <= md_c;
					moved_q   <= moved_c;
					ok_q      <= ok_c;
					shift32_q <= moved_c;
					diff_q    <= diff_c;
					base_q    <= moved_c ? rf_c : ex_c;
					d_q       <= d_c;
					acc_q     <= '0;
					k_q       <= '0;
					if (!moved_c) begin
						thr_q   <= dcd_pkg::THR_W'(d_c);
						state_q <= ST_MUL;
					end else if (!trk_q) begin
						thr_q   <= dcd_pkg::THR_W'({d_c, 16'h0000});
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_THR;
					end
				end
				ST_THR: begin
					// scaled overshoot threshold, delta times scale
					thr_q   <= dcd_pkg::THR_W'(prod[dcd_pkg::DELTA_W+dcd_pkg::SCALE_W-1:0]);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					acc_q <= acc_q + (AW'(prod) << {k_q, 4'b0000});
					if (k_q == 2'(dcd_pkg::DIGITS - 1)) begin
						state_q <= ST_CMP;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_CMP: begin
					started_q[trk_q] <= 1'b1;
					if (moved_q) begin
						extreme_q[trk_q]   <= price_q;
						reference_q[trk_q] <= pass ? price_q : ref_eff_q;
						mode_down_q[trk_q] <= md_eff_q;
					end else if (pass) begin
						extreme_q[trk_q]   <= price_q;
						reference_q[trk_q] <= price_q;
						mode_down_q[trk_q] <= !md_eff_q;
					end else begin
						extreme_q[trk_q]   <= ext_eff_q;
						reference_q[trk_q] <= ref_eff_q;
						mode_down_q[trk_q] <= md_eff_q;
					end
					if (!trk_q) begin
						ev_plain_q <= ev_c;
						trk_q      <= 1'b1;
						state_q    <= ST_SETUP;
					end else begin
						ev_scaled_q <= ev_c;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!events_valid_q || events.ready) begin
						out_plain_q    <= ev_plain_q;
						out_scaled_q   <= ev_scaled_q;
						events_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_accept_starts_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> (state_q == ST_SETUP && !trk_q))
		else $error("accepted word did not start the plain tracker");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(events_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result word raised outside the output step");

	a_both_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && trk_q) |=> (started_q == 2'b11))
		else $error("trackers not seeded after a full pass");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (k_q != 2'd3))
		else $error("multiplier digit out of range");

endmodule
